### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; compiled out with
// NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### sv/ttdp_pkg.sv
// ---------------------------------------------------------------------------
// ttdp_pkg
// Types and constants of the tone timer divisor programmer.
// ---------------------------------------------------------------------------
`default_nettype none

package ttdp_pkg;

    localparam int NUM_CHANNELS = 3;

    localparam int DIVIDEND_W = 24;
    localparam int DIVISOR_W  = 16;
    localparam int TONE_W     = 16;
    localparam int COUNT_W    = 5;

    localparam logic [DIVIDEND_W-1:0] INPUT_CLOCK_RESET = 24'd4000000;
    localparam logic [TONE_W-1:0]     MAX_TONE_RESET    = 16'd15000;

    // Access mode codes per channel
    typedef logic [2:0] mode_t;
    localparam mode_t MODE_LATCH     = 3'd0;
    localparam mode_t MODE_LOW       = 3'd1;
    localparam mode_t MODE_HIGH      = 3'd2;
    localparam mode_t MODE_PAIR_LOW  = 3'd3;
    localparam mode_t MODE_PAIR_HIGH = 3'd4;

    // Input word kind (carried on tuser)
    localparam logic KIND_CONTROL = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    // Configuration register indexes
    localparam logic CFG_INPUT_CLOCK = 1'b0;
    localparam logic CFG_MAX_TONE    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

endpackage

`default_nettype wire

### sv/tone_timer_divisor_programmer.sv
// ---------------------------------------------------------------------------
// tone_timer_divisor_programmer
// Programs three tone channel divisors in 8253 style and reports each new
// tone frequency, worked out by a bit-serial divider.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries CPU port writes: tuser is the kind (control word or
//   divisor data), tdata holds the channel and the written byte. A control
//   word sets a channel's access mode; a data write loads divisor bytes.
//   When a divisor becomes complete, one word leaves on m_axis holding the
//   channel and input_clock_hz / divisor, clamped to max_tone_hz (0 for a
//   zero divisor). Other writes give no result word.
//   Timing: a write that gives no result leaves s_axis tready high. A
//   completed divisor runs the shared restoring divider, one quotient
//   bit per cycle, then is clamped into the output register (a zero
//   divisor skips the divider). s_axis tready is low from the accept
//   of such a write until its result is loaded into the output register,
//   so the divider loop sets the rate of results.
//   A stalled receiver holds the result in the output register; the block
//   still takes the next write, and parks a further result until the
//   register frees up.
//   Reset clears all divisors to zero, all modes to latch, and loads
//   input_clock_hz = 4000000 and max_tone_hz = 15000. The user must write
//   the config port only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tone_timer_divisor_programmer
    import ttdp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [1:0] channel, [9:2] data_byte
    input  wire logic        s_axis_tuser,  // [0] kind
    // Result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // [1:0] out_channel, [17:2] tone_hz
    // Configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_data
);

    // Configuration registers
    logic [DIVIDEND_W-1:0] input_clock_reg;
    logic [TONE_W-1:0]     max_tone_reg;

    // Channel state
    mode_t                 mode_reg    [NUM_CHANNELS];
    logic [DIVISOR_W-1:0]  divisor_reg [NUM_CHANNELS];

    // Sequencer and divider datapath
    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [DIVIDEND_W-1:0] work_reg;     // dividend bits out, quotient bits in
    logic [DIVISOR_W:0]    rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [1:0]            chan_reg;

    // Output register
    logic                  m_valid_reg;
    logic [1:0]            m_chan_reg;
    logic [TONE_W-1:0]     m_tone_reg;

    // Input decode
    logic                  accept;
    logic                  in_kind;
    logic [1:0]            in_chan;
    logic [7:0]            in_byte;
    logic [1:0]            ctl_sel;
    logic                  ctl_sel_ok;
    logic                  chan_ok;
    logic [1:0]            chan_idx;
    mode_t                 cur_mode;
    logic [DIVISOR_W-1:0]  cur_div;
    mode_t                 new_mode;
    logic [DIVISOR_W-1:0]  new_div;
    logic                  div_done;
    logic                  data_upd;
    logic                  start_div;
    logic                  start_zero;

    // Divider step
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  q_bit;
    logic                  last_step;

    // Clamp and output load
    logic [TONE_W-1:0]     tone_clamped;
    logic                  out_free;
    logic                  out_load;

    assign in_kind    = s_axis_tuser;
    assign in_chan    = s_axis_tdata[1:0];
    assign in_byte    = s_axis_tdata[9:2];
    assign ctl_sel    = in_byte[7:6];
    assign ctl_sel_ok = (int'(ctl_sel) < NUM_CHANNELS);
    assign chan_ok    = (int'(in_chan) < NUM_CHANNELS);
    assign chan_idx   = chan_ok ? in_chan : 2'd0;
    assign cur_mode   = mode_reg[chan_idx];
    assign cur_div    = divisor_reg[chan_idx];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Byte loading per access mode; latch and unused codes ignore the write
    always_comb
    begin
        new_mode = cur_mode;
        new_div  = cur_div;
        div_done = 1'b0;
        case (cur_mode)
            MODE_LOW:
            begin
                new_div  = {cur_div[15:8], in_byte};
                div_done = 1'b1;
            end
            MODE_HIGH:
            begin
                new_div  = {in_byte, cur_div[7:0]};
                div_done = 1'b1;
            end
            MODE_PAIR_LOW:
            begin
                new_div  = {cur_div[15:8], in_byte};
                new_mode = MODE_PAIR_HIGH;
            end
            MODE_PAIR_HIGH:
            begin
                new_div  = {in_byte, cur_div[7:0]};
                new_mode = MODE_PAIR_LOW;
                div_done = 1'b1;
            end
            default:
            begin
                new_mode = cur_mode;
            end
        endcase
    end

    assign data_upd   = accept && (in_kind == KIND_DATA) && chan_ok;
    assign start_div  = data_upd && div_done && (new_div != '0);
    assign start_zero = data_upd && div_done && (new_div == '0);

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg[DIVISOR_W-1:0], work_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign q_bit     = (rem_shift >= {1'b0, den_reg});
    assign last_step = (count_reg == COUNT_W'(DIVIDEND_W - 1));

    assign tone_clamped = (work_reg > {{(DIVIDEND_W-TONE_W){1'b0}}, max_tone_reg})
                        ? max_tone_reg : work_reg[TONE_W-1:0];
    assign out_free = !m_valid_reg || m_axis_tready;
    assign out_load = (state_reg == ST_HOLD) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_div)
                    state_next = ST_DIV;
                else if (start_zero)
                    state_next = ST_HOLD;
            end
            ST_DIV:
            begin
                if (last_step)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_clock_reg <= INPUT_CLOCK_RESET;
            max_tone_reg    <= MAX_TONE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_INPUT_CLOCK)
                input_clock_reg <= cfg_data;
            else if (cfg_index == CFG_MAX_TONE)
                max_tone_reg <= cfg_data[TONE_W-1:0];
        end
    end

    // Channel modes and divisors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                mode_reg[i]    <= MODE_LATCH;
                divisor_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (in_kind == KIND_CONTROL)
            begin
                if (ctl_sel_ok)
                    mode_reg[ctl_sel] <= {1'b0, in_byte[5:4]};
            end
            else if (chan_ok)
            begin
                mode_reg[chan_idx]    <= new_mode;
                divisor_reg[chan_idx] <= new_div;
            end
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Divider datapath: load on start, advance one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start_div)
        begin
            work_reg  <= input_clock_reg;
            rem_reg   <= '0;
            den_reg   <= new_div;
            count_reg <= '0;
            chan_reg  <= in_chan;
        end
        else if (start_zero)
        begin
            work_reg <= '0;
            chan_reg <= in_chan;
        end
        else if (state_reg == ST_DIV)
        begin
            work_reg  <= {work_reg[DIVIDEND_W-2:0], q_bit};
            rem_reg   <= q_bit ? rem_diff : rem_shift;
            count_reg <= count_reg + COUNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_chan_reg <= chan_reg;
            m_tone_reg <= tone_clamped;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, m_tone_reg, m_chan_reg};

    // Checks
    `ASSERT_NEXT(a_div_ends, clk, rst_n, (state_reg == ST_DIV) && last_step,
        state_reg == ST_HOLD, "divider did not hand over after the last step")
    `ASSERT_SAME(a_den_nonzero, clk, rst_n, state_reg == ST_DIV,
        den_reg != '0, "divider running on a zero divisor")
    `ASSERT_NEXT(a_hold_loads, clk, rst_n, out_load,
        m_valid_reg && (state_reg == ST_IDLE), "result not loaded into output register")
    `ASSERT_NEXT(a_ctl_no_result, clk, rst_n, accept && (in_kind == KIND_CONTROL),
        state_reg == ST_IDLE, "control word started a result")

endmodule

`default_nettype wire
